[rtl/pidsc_pkg.sv]
`default_nettype none
package pidsc_pkg;
   localparam int SigW    = 32;
   localparam int GainW   = 24;
   localparam int DtW     = 16;
   localparam int IntegW  = 48;
   localparam int DriveW  = 16;
   localparam int DiffW   = 33;
   localparam int DerivW  = 50;
   localparam int AccW    = 80;
   localparam int CsrIdxW = 2;
   localparam int CntW    = 6;

   localparam logic [CsrIdxW-1:0] CSR_PROP  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_INTEG = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_DERIV = 2'd2;

   localparam logic [GainW-1:0] PROP_RESET  = 24'd3277;
   localparam logic [GainW-1:0] INTEG_RESET = 24'd6554;
   localparam logic [GainW-1:0] DERIV_RESET = 24'd0;

   localparam logic signed [DriveW-1:0] DRIVE_ONE = 16'sd16384;

   typedef logic signed [AccW-1:0] acc_type;
endpackage
`default_nettype wire

[rtl/pid_speed_controller.sv]
// Channel | Direction | Ports                                          | Handshake
// req     | in        | req_setpoint/speed_valid/measured_speed/elapsed | req_valid/req_ready
// rsp     | out       | rsp_drive                                      | rsp_valid/rsp_ready
// csr     | in        | csr_index, csr_data                            | csr_write
//
// One item at a time. An item that yields a drive is offered on rsp once it has passed
// through the error, e*dt, integral, bit-serial divider, three gain products (one multiplier
// bit per cycle) and clamp steps in that order. An item with no result leaves the block
// idle, so the next item can be taken on the following cycle.
// Reset is synchronous and clears the loop state and the gains to their defaults.
// A finished drive waits in rsp_drive; req_ready is low until it is taken.
`default_nettype none
module pid_speed_controller
   import pidsc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [SigW-1:0]    req_setpoint,
   input  wire logic                      req_speed_valid,
   input  wire logic signed [SigW-1:0]    req_measured_speed,
   input  wire logic [DtW-1:0]            req_elapsed,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [DriveW-1:0]       rsp_drive,
   input  wire logic                      csr_write,
   input  wire logic [CsrIdxW-1:0]        csr_index,
   input  wire logic [GainW-1:0]          csr_data
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ERR   = 4'd1;
   localparam logic [3:0] S_INC   = 4'd2;   // e*dt, 16 multiplier bits
   localparam logic [3:0] S_INTEG = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;   // restoring divide of |diff|<<16 by dt
   localparam logic [3:0] S_MP    = 4'd5;   // Kp*e
   localparam logic [3:0] S_MI    = 4'd6;   // Ki*integral
   localparam logic [3:0] S_MD    = 4'd7;   // Kd*deriv
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_RSP   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic signed [GainW-1:0] kp_ff, ki_ff, kd_ff;
   logic signed [SigW-1:0] held_ff, held_in, prev_ff, prev_in, sp_ff, sp_in;
   logic seen_ff, seen_in;
   logic signed [IntegW-1:0] integ_ff, integ_in;
   logic [DtW-1:0] dt_ff, dt_in;
   logic signed [SigW-1:0] e_ff, e_in;
   // multiplicand is sign-extended to the accumulator; multiplier shifts out one bit a cycle
   acc_type mcand_ff, mcand_in, prod_ff, prod_in, sum_ff, sum_in;
   logic [DerivW-1:0] mplier_ff, mplier_in;
   // divider
   logic [DerivW-1:0] quo_ff, quo_in;
   logic [DtW-1:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic signed [DerivW-1:0] deriv_ff, deriv_in;
   logic signed [DriveW-1:0] drive_ff, drive_in;
   logic rspv_ff, rspv_in;

   logic signed [DiffW-1:0] diff_w;
   logic [DiffW-1:0] mag_w;
   logic [DtW:0] trial_w;
   logic signed [IntegW:0] isum_w;
   logic signed [SigW:0] esum_w;
   acc_type addend_w, shifted_w;

   assign req_ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_drive = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= PROP_RESET;
         ki_ff <= INTEG_RESET;
         kd_ff <= DERIV_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PROP:  kp_ff <= csr_data;
            CSR_INTEG: ki_ff <= csr_data;
            CSR_DERIV: kd_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; held_in = held_ff; seen_in = seen_ff;
      prev_in = prev_ff; integ_in = integ_ff; sp_in = sp_ff; dt_in = dt_ff;
      e_in = e_ff; mcand_in = mcand_ff; prod_in = prod_ff; sum_in = sum_ff;
      mplier_in = mplier_ff; quo_in = quo_ff; rem_in = rem_ff; neg_in = neg_ff;
      deriv_in = deriv_ff; drive_in = drive_ff; rspv_in = rspv_ff;
      diff_w = DiffW'(e_ff) - DiffW'(prev_ff);
      mag_w = diff_w[DiffW-1] ? DiffW'(-diff_w) : DiffW'(diff_w);
      trial_w = {rem_ff, mplier_ff[DerivW-1]};
      isum_w = (IntegW+1)'(integ_ff) + (IntegW+1)'(prod_ff >>> 16);
      esum_w = (SigW+1)'(sp_ff) - (SigW+1)'(held_ff);
      addend_w = mplier_ff[0] ? mcand_ff : '0;
      shifted_w = mcand_ff <<< 1;
      if (rspv_ff && rsp_ready) rspv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            // take the measurement first: it counts on this same item
            if (req_speed_valid) begin held_in = req_measured_speed; seen_in = 1'b1; end
            sp_in = req_setpoint; dt_in = req_elapsed;
            if ((req_speed_valid || seen_ff) && req_elapsed != '0) state_in = S_ERR;
         end
         S_ERR: begin
            // saturate the error to 32 bits, then start e*dt
            if (esum_w[SigW] != esum_w[SigW-1])
               e_in = esum_w[SigW] ? {1'b1, {(SigW-1){1'b0}}} : {1'b0, {(SigW-1){1'b1}}};
            else e_in = esum_w[SigW-1:0];
            mcand_in = AccW'(e_in);
            mplier_in = DerivW'(dt_ff);
            prod_in = '0; cnt_in = CntW'(DtW - 1); state_in = S_INC;
         end
         S_INC, S_MP, S_MI, S_MD: begin
            prod_in = prod_ff + addend_w;
            mcand_in = shifted_w;
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               unique case (state_ff)
                  S_INC: state_in = S_INTEG;
                  S_MP: begin
                     sum_in = prod_in;
                     mcand_in = AccW'(integ_ff); mplier_in = DerivW'(ki_ff);
                     prod_in = '0; cnt_in = CntW'(GainW - 1); state_in = S_MI;
                  end
                  S_MI: begin
                     sum_in = sum_ff + prod_in;
                     mcand_in = AccW'(deriv_ff); mplier_in = DerivW'(kd_ff);
                     prod_in = '0; cnt_in = CntW'(GainW - 1); state_in = S_MD;
                  end
                  default: begin
                     sum_in = sum_ff + prod_in;
                     state_in = S_OUT;
                  end
               endcase
            end
            // gain multipliers are signed: last bit subtracts
            if ((state_ff == S_MP || state_ff == S_MI || state_ff == S_MD) && cnt_ff == '0
                && mplier_ff[0]) begin
               if (state_ff == S_MP) sum_in = prod_ff - mcand_ff;
               else sum_in = sum_ff + prod_ff - mcand_ff;
            end
         end
         S_INTEG: begin
            // add floor(e*dt/2^16) to the integral, then saturate at 48 bits
            if (isum_w[IntegW] != isum_w[IntegW-1])
               integ_in = isum_w[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                         : {1'b0, {(IntegW-1){1'b1}}};
            else integ_in = isum_w[IntegW-1:0];
            neg_in = diff_w[DiffW-1];
            mplier_in = {mag_w, 16'd0, 1'b0} >> 1;
            rem_in = '0; quo_in = '0;
            cnt_in = CntW'(DerivW - 1); state_in = S_DIV;
         end
         S_DIV: begin
            mplier_in = mplier_ff << 1;
            if (trial_w >= {1'b0, dt_ff}) begin
               rem_in = DtW'(trial_w - {1'b0, dt_ff}); quo_in = {quo_ff[DerivW-2:0], 1'b1};
            end else begin
               rem_in = trial_w[DtW-1:0]; quo_in = {quo_ff[DerivW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               deriv_in = neg_ff ? DerivW'(-quo_in) : quo_in;
               prev_in = e_ff;
               mcand_in = AccW'(e_ff); mplier_in = DerivW'(kp_ff);
               prod_in = '0; cnt_in = CntW'(GainW - 1); state_in = S_MP;
            end
         end
         S_OUT: begin
            // floor(sum/2^18), clamp to plus or minus one
            if ((sum_ff >>> 18) > AccW'(DRIVE_ONE)) drive_in = DRIVE_ONE;
            else if ((sum_ff >>> 18) < -AccW'(DRIVE_ONE)) drive_in = -DRIVE_ONE;
            else drive_in = sum_ff[18 +: DriveW];
            rspv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rspv_ff <= 1'b0; seen_ff <= 1'b0;
         held_ff <= '0; prev_ff <= '0; integ_ff <= '0;
      end else begin
         state_ff <= state_in; rspv_ff <= rspv_in; seen_ff <= seen_in;
         held_ff <= held_in; prev_ff <= prev_in; integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; sp_ff <= sp_in; dt_ff <= dt_in; e_ff <= e_in;
      mcand_ff <= mcand_in; prod_ff <= prod_in; sum_ff <= sum_in;
      mplier_ff <= mplier_in; quo_ff <= quo_in; rem_ff <= rem_in; neg_ff <= neg_in;
      deriv_ff <= deriv_in; drive_ff <= drive_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE)) else $error("ready outside idle");
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= DRIVE_ONE && rsp_drive >= -DRIVE_ONE))
      else $error("drive out of range");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> rsp_valid) else $error("result lost");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> !req_ready) else $error("accept while result held");
endmodule
`default_nettype wire
